// ----- design/lpht_pkg.sv -----
// ----------------------------------------------------------------------------
// lpht_pkg
// Shared types and constants of the linear-probe hash table.
// ----------------------------------------------------------------------------
`default_nettype none
package lpht_pkg;
    localparam int CAPACITY_DEF   = 256;
    localparam int KEY_BITS_DEF   = 32;
    localparam int VALUE_BITS_DEF = 32;
    localparam int HASH_BITS_DEF  = 32;
    localparam int QUEUE_DEPTH    = 2;
    localparam int LIMIT_BITS     = 9;
    localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 9'd128;

    typedef enum logic [1:0] {
        OP_GET = 2'd0,
        OP_ADD = 2'd1,
        OP_SET = 2'd2,
        OP_REM = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_NEW  = 3'd0,
        ST_HIT  = 3'd1,
        ST_MISS = 3'd2,
        ST_DUP  = 3'd3,
        ST_FULL = 3'd4
    } t_status;

    localparam int REQ_BITS = 98;
    localparam int RSP_BITS = 44;
endpackage
`default_nettype wire

// ----- design/lpht_front.sv -----
// ----------------------------------------------------------------------------
// lpht_front
// Accepts request beats and queues them for the back part.
// ----------------------------------------------------------------------------
`default_nettype none
module lpht_front #(
    parameter int DEPTH = lpht_pkg::QUEUE_DEPTH
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_valid,
    output logic                         o_ready,
    input  wire [lpht_pkg::REQ_BITS-1:0] i_req,
    output logic                         o_valid,
    input  wire                          i_ready,
    output logic [lpht_pkg::REQ_BITS-1:0] o_req
);
    import lpht_pkg::*;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [REQ_BITS-1:0] r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;
    logic          push, pop;

    assign o_ready = (r_cnt != (AW+1)'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;
    assign o_req   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_req;
        end
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
            if (pop)  r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(push) - (AW+1)'(pop);
        end
    end
endmodule
`default_nettype wire

// ----- design/lpht_back.sv -----
// ----------------------------------------------------------------------------
// lpht_back
// Probe engine: walks the slot memory slot by slot, one request at a time, and updates it.
// ----------------------------------------------------------------------------
`default_nettype none
module lpht_back #(
    parameter int CAPACITY   = lpht_pkg::CAPACITY_DEF,
    parameter int KEY_BITS   = lpht_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS = lpht_pkg::VALUE_BITS_DEF,
    parameter int HASH_BITS  = lpht_pkg::HASH_BITS_DEF
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire [lpht_pkg::LIMIT_BITS-1:0] i_limit,
    input  wire                            i_valid,
    output logic                           o_ready,
    input  wire [lpht_pkg::REQ_BITS-1:0]   i_req,
    output logic                           o_valid,
    input  wire                            i_ready,
    output logic [lpht_pkg::RSP_BITS-1:0]  o_rsp
);
    import lpht_pkg::*;
    localparam int SW = $clog2(CAPACITY);
    localparam int CW = SW + 1;

    // Slot flag codes: bit 0 used, bit 1 deleted.
    localparam logic [1:0] FLAG_NONE = 2'b00;
    localparam logic [1:0] FLAG_LIVE = 2'b01;
    localparam logic [1:0] FLAG_GONE = 2'b11;

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_READ  = 6'b000100,
        S_CHECK = 6'b001000,
        S_WRITE = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    // Flags and payload all live in memories; the flags are cleared by a
    // pass over every slot after reset.
    logic [1:0]            m_flag [CAPACITY];
    logic [HASH_BITS-1:0]  m_hash [CAPACITY];
    logic [KEY_BITS-1:0]   m_key  [CAPACITY];
    logic [VALUE_BITS-1:0] m_val  [CAPACITY];
    logic [1:0]            r_rd_f;
    logic [HASH_BITS-1:0]  r_rd_h;
    logic [KEY_BITS-1:0]   r_rd_k;
    logic [VALUE_BITS-1:0] r_rd_v;

    t_state r_state;
    t_op    r_op;
    logic [HASH_BITS-1:0]  r_h;
    logic [KEY_BITS-1:0]   r_k;
    logic [VALUE_BITS-1:0] r_v;
    logic [SW-1:0] r_s, r_free, r_wslot;
    logic [CW-1:0] r_n;
    logic          r_have_free, r_wr_match;
    logic [CW-1:0] r_live;
    logic [2:0]    r_status;
    logic [31:0]   r_old;

    logic used_s, del_s, live_s, hit_gr, hit_as, last;
    logic          flag_we;
    logic [SW-1:0] flag_addr;
    logic [1:0]    flag_wd;

    assign used_s = r_rd_f[0];
    assign del_s  = r_rd_f[1];
    assign live_s = used_s && !del_s;
    assign hit_gr = live_s && (r_rd_h == r_h) && (r_rd_k == r_k);
    assign hit_as = live_s && (r_rd_k == r_k);
    assign last   = (r_n == CW'(CAPACITY - 1));

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_OUT);
    assign o_rsp   = {LIMIT_BITS'(r_live), r_old, r_status};

    // One flag write a cycle: clearing pass, tombstone on remove, or store.
    always_comb begin
        flag_we   = 1'b0;
        flag_addr = r_s;
        flag_wd   = FLAG_NONE;
        case (r_state)
            S_CLEAR: flag_we = 1'b1;
            S_CHECK: begin
                if (r_op == OP_REM && hit_gr) begin
                    flag_we = 1'b1;
                    flag_wd = FLAG_GONE;
                end
            end
            S_WRITE: begin
                flag_we   = 1'b1;
                flag_addr = r_wslot;
                flag_wd   = FLAG_LIVE;
            end
            default: flag_we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_READ) begin
            r_rd_f <= m_flag[r_s];
            r_rd_h <= m_hash[r_s];
            r_rd_k <= m_key[r_s];
            r_rd_v <= m_val[r_s];
        end
        if (flag_we) begin
            m_flag[flag_addr] <= flag_wd;
        end
        if (r_state == S_WRITE && r_wr_match) begin
            m_hash[r_wslot] <= r_h;
            m_key[r_wslot]  <= r_k;
            m_val[r_wslot]  <= r_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_s     <= '0;
            r_live  <= '0;
        end else begin
            case (r_state)
                S_CLEAR: begin
                    r_s <= r_s + 1'b1;
                    if (r_s == SW'(CAPACITY - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_valid) begin
                        r_op <= t_op'(i_req[1:0]);
                        r_h  <= i_req[2 +: HASH_BITS];
                        r_k  <= i_req[34 +: KEY_BITS];
                        r_v  <= i_req[66 +: VALUE_BITS];
                        r_s  <= i_req[2 +: SW];
                        r_n  <= '0;
                        r_have_free <= 1'b0;
                        r_old <= '0;
                        if ((t_op'(i_req[1:0]) == OP_ADD || t_op'(i_req[1:0]) == OP_SET)
                            && (9'(r_live) > i_limit)) begin
                            r_status <= ST_FULL;
                            r_state  <= S_OUT;
                        end else begin
                            r_state <= S_READ;
                        end
                    end
                end
                S_READ: r_state <= S_CHECK;
                S_CHECK: begin
                    r_wr_match <= 1'b0;
                    r_state    <= S_OUT;
                    if (r_op == OP_GET || r_op == OP_REM) begin
                        if (!used_s) begin
                            r_status <= ST_MISS;
                        end else if (hit_gr) begin
                            r_status <= ST_HIT;
                            r_old    <= 32'(r_rd_v);
                            if (r_op == OP_REM) begin
                                r_live <= r_live - 1'b1;
                            end
                        end else if (last) begin
                            r_status <= ST_MISS;
                        end else begin
                            r_s <= r_s + 1'b1;
                            r_n <= r_n + 1'b1;
                            r_state <= S_READ;
                        end
                    end else begin
                        if (hit_as) begin
                            if (r_op == OP_ADD) begin
                                r_status <= ST_DUP;
                            end else begin
                                r_status   <= ST_HIT;
                                r_old      <= 32'(r_rd_v);
                                r_wslot    <= r_s;
                                r_wr_match <= 1'b1;
                                r_state    <= S_WRITE;
                            end
                        end else if (!used_s || last) begin
                            if (r_have_free || !used_s || del_s) begin
                                r_wslot    <= r_have_free ? r_free : r_s;
                                r_status   <= ST_NEW;
                                r_wr_match <= 1'b1;
                                r_live     <= r_live + 1'b1;
                                r_state    <= S_WRITE;
                            end else begin
                                r_status <= ST_FULL;
                            end
                        end else begin
                            if (del_s && !r_have_free) begin
                                r_have_free <= 1'b1;
                                r_free      <= r_s;
                            end
                            r_s <= r_s + 1'b1;
                            r_n <= r_n + 1'b1;
                            r_state <= S_READ;
                        end
                    end
                end
                S_WRITE: r_state <= S_OUT;
                S_OUT: if (i_ready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ----- design/linear_probe_hash_table_core.sv -----
// ----------------------------------------------------------------------------
// linear_probe_hash_table_core
// Open-addressing hash table with linear probing and tombstones.
// ----------------------------------------------------------------------------
// A request beat enters a two-deep queue and is served by a probe engine
// that reads the slots one after another, each a registered memory read
// followed by a compare; add and set that store end with a write step, and
// a request refused by the load limit skips the probe altogether. The
// result beat is held until taken, while the queue keeps accepting until it
// holds two beats. After reset the engine clears the slot flags, one slot a
// cycle, over all CAPACITY slots (256 by default) before it serves the first
// request; the queue may take up to two beats meanwhile.
`default_nettype none
module linear_probe_hash_table_core #(
    parameter int CAPACITY   = lpht_pkg::CAPACITY_DEF,
    parameter int KEY_BITS   = lpht_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS = lpht_pkg::VALUE_BITS_DEF,
    parameter int HASH_BITS  = lpht_pkg::HASH_BITS_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire  [8:0]  i_cfg_wdata,     // load_limit
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [1:0]  s_axis_tuser,    // req_type
    input  wire  [95:0] s_axis_tdata,    // hash, key, value
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [2:0]  m_axis_tuser,    // status
    output logic [47:0] m_axis_tdata     // old_value, entry_count, pad
);
    import lpht_pkg::*;

    logic [LIMIT_BITS-1:0] r_limit;
    logic [REQ_BITS-1:0]   req_in, req_q;
    logic                  q_valid, q_ready;
    logic [RSP_BITS-1:0]   rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_limit <= LIMIT_RESET;
        else if (i_cfg_we) r_limit <= i_cfg_wdata;
    end

    // Only the low bits the parameters name are kept.
    assign req_in = {32'(s_axis_tdata[64 +: VALUE_BITS]),
                     32'(s_axis_tdata[32 +: KEY_BITS]),
                     32'(s_axis_tdata[0 +: HASH_BITS]), s_axis_tuser};

    lpht_front #(.DEPTH(QUEUE_DEPTH)) u_front (
        .i_clk, .i_rst_n, .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_req(req_in), .o_valid(q_valid), .i_ready(q_ready), .o_req(req_q));

    lpht_back #(.CAPACITY(CAPACITY), .KEY_BITS(KEY_BITS),
                .VALUE_BITS(VALUE_BITS), .HASH_BITS(HASH_BITS)) u_back (
        .i_clk, .i_rst_n, .i_limit(r_limit), .i_valid(q_valid),
        .o_ready(q_ready), .i_req(req_q), .o_valid(m_axis_tvalid),
        .i_ready(m_axis_tready), .o_rsp(rsp));

    assign m_axis_tuser = rsp[2:0];
    assign m_axis_tdata = {7'd0, rsp[RSP_BITS-1:3]};

`ifndef ASSERT_OFF
    // Status stays in the legal range of codes.
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser <= ST_FULL)) else $error("bad status");
    // Entry count never exceeds the capacity.
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (32'(m_axis_tdata[40:32]) <= CAPACITY))
        else $error("count overflow");
    // Old value is zero unless the status is a hit.
    a_old: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser != ST_HIT) |-> (m_axis_tdata[31:0] == 32'd0))
        else $error("old value without hit");
`endif
endmodule
`default_nettype wire

// ----- sim/lpht_checker.sv -----
// ----------------------------------------------------------------------------
// lpht_checker
// Watches the request, result and load-limit ports of the hash table core,
// keeps its own copy of the table and compares every result beat.
// ----------------------------------------------------------------------------
module lpht_checker
    import lpht_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire  [8:0]  i_cfg_wdata,
    input  wire         i_req_valid,
    input  wire         i_req_ready,
    input  wire  [1:0]  i_req_user,
    input  wire  [95:0] i_req_data,
    input  wire         i_rsp_valid,
    input  wire         i_rsp_ready,
    input  wire  [2:0]  i_rsp_user,
    input  wire  [47:0] i_rsp_data,
    output int          o_errors,
    output int          o_pending
);
    typedef struct packed {
        t_status     st;
        logic [31:0] old;
        logic [8:0]  cnt;
    } t_outcome;

    logic        used_q  [256];
    logic        gone_q  [256];
    logic [31:0] hash_q  [256];
    logic [31:0] key_q   [256];
    logic [31:0] val_q   [256];
    logic [8:0]  live_q;
    logic [8:0]  limit_q;
    t_outcome    outcomes_due[$];

    // Works out the outcome of one request and updates the table copy.
    function automatic t_outcome lookup_and_update(input t_op op, input logic [31:0] h,
                                                   input logic [31:0] k,
                                                   input logic [31:0] v);
        t_outcome    res;
        logic [7:0]  idx;
        logic [7:0]  free_idx;
        logic        have_free;
        logic        matched;
        res.st   = ST_MISS;
        res.old  = '0;
        idx      = h[7:0];
        free_idx = '0;
        have_free = 1'b0;
        matched  = 1'b0;
        if (op == OP_GET || op == OP_REM) begin
            for (int n = 0; n < 256; n++) begin
                if (!used_q[idx]) break;
                if (!gone_q[idx] && hash_q[idx] == h && key_q[idx] == k) begin
                    res.old = val_q[idx];
                    res.st  = ST_HIT;
                    if (op == OP_REM) begin
                        gone_q[idx] = 1'b1;
                        live_q      = live_q - 9'd1;
                    end
                    break;
                end
                idx = idx + 8'd1;
            end
        end else if (live_q > limit_q) begin
            res.st = ST_FULL;
        end else begin
            for (int n = 0; n < 256; n++) begin
                if (!used_q[idx]) begin
                    if (!have_free) begin
                        have_free = 1'b1;
                        free_idx  = idx;
                    end
                    break;
                end
                if (gone_q[idx]) begin
                    if (!have_free) begin
                        have_free = 1'b1;
                        free_idx  = idx;
                    end
                end else if (key_q[idx] == k) begin
                    matched = 1'b1;
                    break;
                end
                idx = idx + 8'd1;
            end
            if (matched) begin
                if (op == OP_ADD) begin
                    res.st = ST_DUP;
                end else begin
                    res.old     = val_q[idx];
                    res.st      = ST_HIT;
                    hash_q[idx] = h;
                    key_q[idx]  = k;
                    val_q[idx]  = v;
                end
            end else if (have_free) begin
                used_q[free_idx] = 1'b1;
                gone_q[free_idx] = 1'b0;
                hash_q[free_idx] = h;
                key_q[free_idx]  = k;
                val_q[free_idx]  = v;
                live_q           = live_q + 9'd1;
                res.st           = ST_NEW;
            end else begin
                res.st = ST_FULL;
            end
        end
        res.cnt = live_q;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_outcome want;
        if (!i_rst_n) begin
            for (int i = 0; i < 256; i++) begin
                used_q[i] = 1'b0;
                gone_q[i] = 1'b0;
            end
            live_q  = '0;
            limit_q = LIMIT_RESET;
            outcomes_due.delete();
        end else begin
            if (i_cfg_we) limit_q = i_cfg_wdata;
            if (i_req_valid && i_req_ready)
                outcomes_due.push_back(lookup_and_update(t_op'(i_req_user),
                    i_req_data[31:0], i_req_data[63:32], i_req_data[95:64]));
            if (i_rsp_valid && i_rsp_ready) begin
                if (outcomes_due.size() == 0) begin
                    $error("result beat with no request outstanding");
                    o_errors++;
                end else begin
                    want = outcomes_due.pop_front();
                    if (i_rsp_user != want.st) begin
                        $error("status: expected %0d, got %0d", want.st, i_rsp_user);
                        o_errors++;
                    end
                    if (i_rsp_data[31:0] != want.old) begin
                        $error("old_value: expected %h, got %h", want.old, i_rsp_data[31:0]);
                        o_errors++;
                    end
                    if (i_rsp_data[40:32] != want.cnt) begin
                        $error("entry_count: expected %0d, got %0d", want.cnt,
                               i_rsp_data[40:32]);
                        o_errors++;
                    end
                end
            end
        end
        o_pending = outcomes_due.size();
    end
endmodule

// ----- sim/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the linear-probe hash table core.
// ----------------------------------------------------------------------------
// A short directed sequence walks through hits, misses, duplicates,
// tombstones and wrap-round; then random traffic on a small pool of keys
// under several load limits; finally the table is filled to the brim so
// that probes run the whole table. The checker beside the core does all
// prediction and comparison.
module tb;
    import lpht_pkg::*;

    localparam int CYCLE_LIMIT = 10_000_000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [8:0]  i_cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    wire         s_axis_tready;
    logic [1:0]  s_axis_tuser = '0;   // req_type
    logic [95:0] s_axis_tdata = '0;   // hash, key, value
    wire         m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    wire  [2:0]  m_axis_tuser;        // status
    wire  [47:0] m_axis_tdata;        // old_value, entry_count, pad

    int          errors;
    int          pending;
    int          cycles = 0;
    int          burst_left = 0;
    bit          hold_req = 1'b0;

    // Pool of keys for the random traffic, each with the hash it lives under.
    logic [31:0] pool_key  [48];
    logic [31:0] pool_hash [48];
    logic [31:0] filled_hash[$];
    logic [31:0] filled_key[$];

    always #2 i_clk = ~i_clk;

    linear_probe_hash_table_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tdata  (m_axis_tdata)
    );

    lpht_checker chk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req_valid (s_axis_tvalid),
        .i_req_ready (s_axis_tready),
        .i_req_user  (s_axis_tuser),
        .i_req_data  (s_axis_tdata),
        .i_rsp_valid (m_axis_tvalid),
        .i_rsp_ready (m_axis_tready),
        .i_rsp_user  (m_axis_tuser),
        .i_rsp_data  (m_axis_tdata),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    // Watchdog: a hung core must not hang the run.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Result side. The receiver switches between patterns of its own: always
    // ready, coin-toss and mostly stalled. When asked, it holds off for a long
    // stretch so that the core's queue fills and it refuses request beats.
    initial begin
        int seg_left;
        int mode;
        seg_left = 0;
        mode     = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (300) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                if (seg_left == 0) begin
                    seg_left = $urandom_range(1, 40);
                    mode     = $urandom_range(0, 2);
                end
                seg_left--;
                case (mode)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= 1'($urandom_range(0, 1));
                    default: m_axis_tready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    // Offers one request beat and returns at the edge where it is taken.
    // Within a burst tvalid stays high from one beat to the next; between
    // bursts it drops for a random gap, sometimes of zero length.
    task automatic send_req(input t_op op, input logic [31:0] h, input logic [31:0] k,
                            input logic [31:0] v);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {v, k, h};
        do @(posedge i_clk); while (!s_axis_tready);
        burst_left--;
    endtask

    // Lets every outstanding result drain before the load limit is touched.
    task automatic drain_all();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [8:0] lim);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= lim;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Random traffic on the key pool. Most requests use a pool key under its
    // own hash so that hits, duplicates and removals are common; the rest are
    // stray hashes and keys.
    task automatic pool_traffic(input int count);
        int          p;
        int          pick;
        t_op         op;
        logic [31:0] h;
        logic [31:0] k;
        for (int n = 0; n < count; n++) begin
            p    = $urandom_range(0, 47);
            pick = $urandom_range(0, 99);
            op   = (pick < 30) ? OP_GET : (pick < 55) ? OP_ADD : (pick < 75) ? OP_SET : OP_REM;
            h    = ($urandom_range(0, 99) < 85) ? pool_hash[p] : $urandom;
            k    = ($urandom_range(0, 99) < 90) ? pool_key[p] : $urandom;
            if (op == OP_SET && $urandom_range(0, 9) == 0) begin
                h = {24'($urandom), 8'($urandom_range(0, 31))};
                pool_hash[p] = h;
            end
            send_req(op, h, k, $urandom);
        end
    endtask

    initial begin
        int          lim_pick;
        logic [8:0]  seg_limit;
        logic [31:0] h;
        logic [31:0] k;

        // Hashes cluster in the first 32 slots so that probe runs collide.
        for (int i = 0; i < 48; i++) begin
            pool_key[i]  = $urandom;
            pool_hash[i] = {24'($urandom), 8'($urandom_range(0, 31))};
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed walk under the reset load limit.
        send_req(OP_GET, 32'h10, 32'h1, 32'h0);             // miss on an empty table
        send_req(OP_ADD, 32'h10, 32'h1, 32'h0);             // inserted
        send_req(OP_ADD, 32'h10, 32'h1, 32'h5);             // duplicate refused
        send_req(OP_SET, 32'h10, 32'h1, 32'hFFFF_FFFF);     // replaces, old value zero
        send_req(OP_GET, 32'h10, 32'h1, 32'h0);             // hit
        send_req(OP_GET, 32'h110, 32'h1, 32'h0);            // same slot, other hash: miss
        send_req(OP_ADD, 32'h110, 32'h1, 32'h7);            // add matches on key alone
        send_req(OP_ADD, 32'h10, 32'h2, 32'h3);             // collides, lands in next slot
        send_req(OP_REM, 32'h10, 32'h1, 32'hA5A5_A5A5);     // removed, leaves a tombstone
        send_req(OP_REM, 32'h10, 32'h1, 32'h0);             // already gone
        send_req(OP_GET, 32'h10, 32'h2, 32'h0);             // probes past the tombstone
        send_req(OP_ADD, 32'h10, 32'h2, 32'h9);             // duplicate past the tombstone
        send_req(OP_ADD, 32'h10, 32'h3, 32'h4);             // reuses the tombstone
        send_req(OP_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF); // top slot
        send_req(OP_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
        send_req(OP_ADD, 32'hFF, 32'h5, 32'h1);             // wraps round to slot zero
        send_req(OP_GET, 32'hFF, 32'h5, 32'h0);
        send_req(OP_SET, 32'h10010, 32'h2, 32'h1234_5678);  // set moves the stored hash
        send_req(OP_GET, 32'h10, 32'h2, 32'h0);             // old hash now misses
        send_req(OP_GET, 32'h10010, 32'h2, 32'h0);
        send_req(OP_REM, 32'h0, 32'h0, 32'hFFFF_FFFF);
        send_req(OP_GET, 32'h0, 32'h0, 32'h0);

        // A zero limit refuses add and set, even for a key already present.
        drain_all();
        write_limit(9'd0);
        send_req(OP_ADD, 32'h20, 32'h20, 32'h1);
        send_req(OP_SET, 32'h10, 32'h3, 32'h2);
        send_req(OP_GET, 32'h10, 32'h3, 32'h0);

        // Random traffic under a spread of limits; the long receiver hold
        // falls in the second segment.
        for (int seg = 0; seg < 4; seg++) begin
            drain_all();
            lim_pick = $urandom_range(0, 256);
            case (seg)
                0: seg_limit = 9'd40;
                1: seg_limit = 9'd255;
                2: seg_limit = 9'd3;
                default: seg_limit = lim_pick[8:0];
            endcase
            write_limit(seg_limit);
            if (seg == 1) hold_req = 1'b1;
            pool_traffic(300);
        end

        // Fill the whole table: with the top limit only the probe cap stops
        // add, so the last adds run the full table and report full.
        drain_all();
        write_limit(9'd256);
        for (int n = 0; n < 270; n++) begin
            h = $urandom;
            k = $urandom;
            filled_hash.push_back(h);
            filled_key.push_back(k);
            send_req(OP_ADD, h, k, $urandom);
        end
        // Misses that have to visit every slot.
        for (int n = 0; n < 10; n++) send_req(OP_GET, $urandom, $urandom, $urandom);
        // Punch holes, then refill them past the tombstones.
        for (int n = 0; n < 40; n++)
            send_req(OP_REM, filled_hash[n * 5], filled_key[n * 5], $urandom);
        for (int n = 0; n < 30; n++) send_req(OP_SET, $urandom, $urandom, $urandom);
        for (int n = 0; n < 15; n++)
            send_req(OP_ADD, filled_hash[n * 5 + 1], filled_key[n * 5 + 1], $urandom);
        for (int n = 0; n < 15; n++) send_req(OP_ADD, $urandom, $urandom, $urandom);

        drain_all();
        repeat (50) @(posedge i_clk);
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule

// ----- sim.f -----
design/lpht_pkg.sv
design/lpht_front.sv
design/lpht_back.sv
design/linear_probe_hash_table_core.sv
sim/lpht_checker.sv
sim/tb.sv
